// ===== rtl/core/mfha_pkg.sv =====
package mfha_pkg;

	// Frame geometry: one history frame holds 2**FRAME_AW bytes.
	localparam int FRAME_AW    = 18;
	localparam int FRAME_BYTES = 1 << FRAME_AW;
	localparam int HISTORY_MAX = 64;
	localparam int SLOT_W      = $clog2(HISTORY_MAX);

	localparam int ADDR_W     = 24;
	localparam int AVG_W      = 24;
	localparam int HIST_LEN_W = 7;
	localparam int GAIN_W     = 17;
	localparam int PROD_W     = AVG_W + GAIN_W;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [GAIN_W-1:0]     GAIN_ONE        = 17'h10000;
	localparam logic [HIST_LEN_W-1:0] HIST_LEN_RST    = 7'd1;
	localparam logic [7:0]            BLACK_LEVEL_RST = 8'd1;
	localparam logic [7:0]            MARKER_RST      = 8'd0;

	// Register word indexes (paddr[3:2]).
	localparam logic [1:0] REG_HIST_LEN = 2'd0;
	localparam logic [1:0] REG_GAIN     = 2'd1;
	localparam logic [1:0] REG_BLACK    = 2'd2;
	localparam logic [1:0] REG_MARKER   = 2'd3;

	typedef struct packed {
		logic [17:0] byte_index;
		logic [7:0]  pixel_value;
		logic        roi_active;
		logic        mask_present;
		logic        mask_moving;
		logic        frame_end;
	} mfha_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] history_address;
		logic [7:0]        history_byte;
		logic [AVG_W-1:0]  average_value;
		logic              frame_done;
	} mfha_out_t;

endpackage

// ===== rtl/core/mfha_ram.sv =====
module mfha_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/masked_frame_history_and_average_core.sv =====
// Masked frame history writer with a per-byte moving average.
// Input channel pix_*: one colour byte per word with its region and motion flags.
// Output channel res_*: one word per input word, in order, carrying the history
// ring address, the masked history byte, the updated Q8.16 average and the frame
// end flag. Both channels move a word at an edge where valid is high and stall
// is low. Settings must be written over the APB port while the block is idle;
// the block itself does not enforce this. A word accepted at one edge passes
// through the three update stages into the output register, which holds it
// while the receiver stalls. Throughput is one word per cycle unless the receiver
// stalls; a word that reads the average store also stalls while the same byte
// index is still in one of the three update stages, since the store (one write
// port, one registered read port) is written only at the last stage.
// When the receiver stalls, empty stages still fill, so up to four words wait
// in the pipeline before pix_stall rises.
// Reset clears the frame slot and the first-frame flag and returns the settings
// to their reset values. The average store is not cleared: the first frame must
// load every entry before any entry is read; the block does not enforce this.
module masked_frame_history_and_average_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [mfha_pkg::PADDR_W-1:0] paddr,
	input  logic [mfha_pkg::PDATA_W-1:0] pwdata,
	output logic [mfha_pkg::PDATA_W-1:0] prdata,
	output logic                     pready,
	input  logic                     pix_valid,
	output logic                     pix_stall,
	input  mfha_pkg::mfha_in_t       pix_data,
	output logic                     res_valid,
	input  logic                     res_stall,
	output mfha_pkg::mfha_out_t      res_data
);

	import mfha_pkg::*;

	// Settings.
	logic [HIST_LEN_W-1:0] hist_len_q;
	logic [GAIN_W-1:0]     gain_q;
	logic [7:0]            black_q;
	logic [7:0]            marker_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= HIST_LEN_RST;
			gain_q     <= GAIN_ONE;
			black_q    <= BLACK_LEVEL_RST;
			marker_q   <= MARKER_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_HIST_LEN: hist_len_q <= pwdata[HIST_LEN_W-1:0];
				REG_GAIN:     gain_q     <= pwdata[GAIN_W-1:0];
				REG_BLACK:    black_q    <= pwdata[7:0];
				REG_MARKER:   marker_q   <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HIST_LEN: prdata = PDATA_W'(hist_len_q);
			REG_GAIN:     prdata = PDATA_W'(gain_q);
			REG_BLACK:    prdata = PDATA_W'(black_q);
			REG_MARKER:   prdata = PDATA_W'(marker_q);
			default:      prdata = '0;
		endcase
	end

	// Pipeline valid bits and load enables; a stage loads when empty or draining.
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;
	logic accept, hazard;

	assign ld_s4 = !vld_s4 || !res_stall;
	assign ld_s3 = !vld_s3 || ld_s4;
	assign ld_s2 = !vld_s2 || ld_s3;
	assign ld_s1 = !vld_s1 || ld_s2;

	assign pix_stall = !ld_s1 || hazard;
	assign accept    = pix_valid && !pix_stall;

	// Frame slot and first-frame tracking, at the input side.
	logic [SLOT_W-1:0]     slot_q;
	logic                  loaded_q;
	logic [HIST_LEN_W-1:0] len_eff;
	logic [SLOT_W-1:0]     slot_use;
	logic [HIST_LEN_W-1:0] slot_inc;
	logic [SLOT_W-1:0]     slot_nxt;

	always_comb begin
		if (hist_len_q == '0) begin
			len_eff = HIST_LEN_W'(1);
		end else if (hist_len_q > HIST_LEN_W'(HISTORY_MAX)) begin
			len_eff = HIST_LEN_W'(HISTORY_MAX);
		end else begin
			len_eff = hist_len_q;
		end
		slot_use = (HIST_LEN_W'(slot_q) < len_eff) ? slot_q : '0;
		slot_inc = HIST_LEN_W'(slot_use) + HIST_LEN_W'(1);
		slot_nxt = (slot_inc >= len_eff) ? '0 : slot_inc[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			loaded_q <= 1'b0;
		end else if (accept && pix_data.frame_end) begin
			slot_q   <= slot_nxt;
			loaded_q <= 1'b1;
		end
	end

	// Input decode.
	logic [FRAME_AW-1:0] pos_in;
	logic                ema_in;
	logic [7:0]          hbyte_in;
	logic [AVG_W-1:0]    fixed_in;

	assign pos_in = pix_data.byte_index[FRAME_AW-1:0];
	assign ema_in = pix_data.roi_active && loaded_q;

	always_comb begin
		if (!pix_data.roi_active) begin
			hbyte_in = black_q;
			fixed_in = {black_q, 16'h0000};
		end else begin
			if (pix_data.mask_present && pix_data.mask_moving) begin
				hbyte_in = marker_q;
			end else begin
				hbyte_in = (pix_data.pixel_value > black_q) ? pix_data.pixel_value : black_q;
			end
			fixed_in = {pix_data.pixel_value, 16'h0000};
		end
	end

	// Stage registers.
	mfha_out_t           res_s1, res_s2, res_s3;
	logic [FRAME_AW-1:0] pos_s1, pos_s2, pos_s3;
	logic                ema_s1, ema_s2, ema_s3;
	logic [7:0]          pix_s1;
	logic [AVG_W-1:0]    fixed_s1, fixed_s2, fixed_s3;
	logic [AVG_W-1:0]    avg_s2, avg_s3;
	logic [AVG_W-1:0]    mag_s2;
	logic                neg_s2, neg_s3;
	logic [PROD_W-1:0]   prod_s3;
	mfha_out_t           res_s4;

	// A word that reads its average waits until no older word with the same
	// index is still ahead of the store write.
	assign hazard = ema_in && (
		(vld_s1 && pos_s1 == pos_in) ||
		(vld_s2 && pos_s2 == pos_in) ||
		(vld_s3 && pos_s3 == pos_in));

	// Average store.
	logic [AVG_W-1:0] rd_avg;
	logic [AVG_W-1:0] avg_new_s3;
	logic             st_we;

	assign st_we = vld_s3 && ld_s4;

	mfha_ram #(
		.WIDTH(AVG_W),
		.DEPTH(FRAME_BYTES)
	) u_avg_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(pos_s3),
		.wdata(avg_new_s3),
		.re   (accept),
		.raddr(pos_in),
		.rdata(rd_avg)
	);

	// Stage 1 logic: signed distance to the target, as sign and magnitude.
	logic [AVG_W:0]   diff_s1;
	logic [AVG_W:0]   diff_neg_s1;
	logic [AVG_W-1:0] mag_s1;

	always_comb begin
		diff_s1     = {1'b0, pix_s1, 16'h0000} - {1'b0, rd_avg};
		diff_neg_s1 = (AVG_W+1)'(0) - diff_s1;
		mag_s1      = diff_s1[AVG_W] ? diff_neg_s1[AVG_W-1:0] : diff_s1[AVG_W-1:0];
	end

	// Stage 2 logic: gain clamp.
	logic [GAIN_W-1:0] gain_eff;
	assign gain_eff = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

	// Stage 3 logic: round, apply the step and clamp to the Q8.16 range.
	logic [PROD_W:0]    rnd_s3;
	logic [PROD_W-16:0] step_s3;
	logic [PROD_W-13:0] sum_s3;
	mfha_out_t          res_nxt_s3;

	always_comb begin
		rnd_s3  = {1'b0, prod_s3} + (PROD_W+1)'(32768);
		step_s3 = rnd_s3[PROD_W:16];
		if (neg_s3) begin
			sum_s3 = (PROD_W-12)'(avg_s3) - (PROD_W-12)'(step_s3);
		end else begin
			sum_s3 = (PROD_W-12)'(avg_s3) + (PROD_W-12)'(step_s3);
		end
		if (!ema_s3) begin
			avg_new_s3 = fixed_s3;
		end else if (sum_s3[PROD_W-13]) begin
			avg_new_s3 = '0;
		end else if (sum_s3 > (PROD_W-12)'(24'hFFFFFF)) begin
			avg_new_s3 = 24'hFFFFFF;
		end else begin
			avg_new_s3 = sum_s3[AVG_W-1:0];
		end
		res_nxt_s3               = res_s3;
		res_nxt_s3.average_value = avg_new_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (ld_s1) vld_s1 <= accept;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
			if (ld_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && accept) begin
			res_s1.history_address <= {slot_use, pos_in};
			res_s1.history_byte    <= hbyte_in;
			res_s1.average_value   <= '0;
			res_s1.frame_done      <= pix_data.frame_end;
			pos_s1                 <= pos_in;
			ema_s1                 <= ema_in;
			pix_s1                 <= pix_data.pixel_value;
			fixed_s1               <= fixed_in;
		end
		if (ld_s2 && vld_s1) begin
			res_s2   <= res_s1;
			pos_s2   <= pos_s1;
			ema_s2   <= ema_s1;
			fixed_s2 <= fixed_s1;
			avg_s2   <= rd_avg;
			mag_s2   <= mag_s1;
			neg_s2   <= diff_s1[AVG_W];
		end
		if (ld_s3 && vld_s2) begin
			res_s3   <= res_s2;
			pos_s3   <= pos_s2;
			ema_s3   <= ema_s2;
			fixed_s3 <= fixed_s2;
			avg_s3   <= avg_s2;
			neg_s3   <= neg_s2;
			prod_s3  <= PROD_W'(mag_s2) * PROD_W'(gain_eff);
		end
		if (ld_s4 && vld_s3) begin
			res_s4 <= res_nxt_s3;
		end
	end

	assign res_valid = vld_s4;
	assign res_data  = res_s4;

endmodule

// ===== rtl/core/mfha_checker.sv =====
module mfha_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     pix_valid,
	input logic                     pix_stall,
	input mfha_pkg::mfha_in_t       pix_data,
	input logic                     res_valid,
	input logic                     res_stall,
	input mfha_pkg::mfha_out_t      res_data
);

	import mfha_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result word changed while stalled");

	// With the receiver open, an accepted word reaches the output without a stall.
	a_latency_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall
		|=> res_valid && res_data.frame_done == $past(pix_data.frame_end, 4))
		else $error("frame end flag lost in pipeline");

	a_latency_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall
		|=> res_data.history_address[FRAME_AW-1:0] ==
			$past(pix_data.byte_index[FRAME_AW-1:0], 4))
		else $error("history address does not match byte index");

endmodule

bind masked_frame_history_and_average_core mfha_checker u_mfha_checker (.*);

// ===== tb/masked_frame_history_and_average_core_tb.sv =====
module masked_frame_history_and_average_core_tb;
	import mfha_pkg::*;

	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLD_CYCLES    = 200;
	localparam int HOLD_AT_RESULT = 1350;
	localparam int DRAIN_LIMIT    = 100000;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               pix_valid = 1'b0;
	logic               pix_stall;
	mfha_in_t           pix_data  = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	mfha_out_t          res_data;

	masked_frame_history_and_average_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always #4 clk = ~clk;

	// Settings as the block should hold them, plus the predicted block state.
	logic [HIST_LEN_W-1:0] set_len    = HIST_LEN_RST;
	logic [GAIN_W-1:0]     set_gain   = GAIN_ONE;
	logic [7:0]            set_black  = BLACK_LEVEL_RST;
	logic [7:0]            set_marker = MARKER_RST;
	logic [AVG_W-1:0]      average_mem [int unsigned];
	bit                    first_frame_seen = 1'b0;
	int unsigned           slot_now = 0;

	mfha_in_t  pixel_words_pending [$];
	mfha_out_t history_expected [$];

	// Generation side bookkeeping, so that no unwritten average is ever read.
	bit               gen_written [int unsigned];
	bit               gen_loaded = 1'b0;
	logic [17:0]      index_pool [32];

	int unsigned words_accepted = 0;
	int unsigned results_seen   = 0;
	int unsigned frames_closed  = 0;
	int unsigned settings_count = 0;
	int unsigned fault_count    = 0;

	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	int unsigned stall_phase_left = 0;
	int unsigned stall_pct  = 0;
	int unsigned hold_left  = 0;
	bit          hold_done  = 1'b0;

	function automatic mfha_out_t predict_history_word(input mfha_in_t w);
		mfha_out_t   o;
		int unsigned ring_len, slot, pos;
		longint      gain, cur, tgt, diff, mag, stp, nxt;
		pos = w.byte_index % FRAME_BYTES;
		ring_len = (set_len == 0) ? 1 : (set_len > HISTORY_MAX) ? HISTORY_MAX : set_len;
		slot = (slot_now < ring_len) ? slot_now : 0;
		if (!w.roi_active)
			o.history_byte = set_black;
		else if (w.mask_present && w.mask_moving)
			o.history_byte = set_marker;
		else
			o.history_byte = (w.pixel_value > set_black) ? w.pixel_value : set_black;
		gain = (set_gain > GAIN_ONE) ? GAIN_ONE : set_gain;
		if (!w.roi_active) begin
			nxt = longint'(set_black) << 16;
		end else if (!first_frame_seen) begin
			nxt = longint'(w.pixel_value) << 16;
		end else begin
			cur = average_mem.exists(pos) ? average_mem[pos] : 0;
			tgt = longint'(w.pixel_value) << 16;
			diff = tgt - cur;
			mag = (diff < 0) ? -diff : diff;
			// Round half away from zero on the magnitude, then apply the sign.
			stp = (mag * gain + 32768) >>> 16;
			nxt = (diff < 0) ? cur - stp : cur + stp;
			if (nxt < 0) nxt = 0;
			if (nxt > longint'(24'hFFFFFF)) nxt = longint'(24'hFFFFFF);
		end
		average_mem[pos] = nxt[AVG_W-1:0];
		o.average_value = nxt[AVG_W-1:0];
		o.history_address = ADDR_W'(longint'(slot) * FRAME_BYTES + pos);
		o.frame_done = w.frame_end;
		if (w.frame_end) begin
			slot = slot + 1;
			if (slot >= ring_len) slot = 0;
			slot_now = slot;
			first_frame_seen = 1'b1;
			frames_closed++;
		end
		return o;
	endfunction

	task automatic queue_fields(input logic [17:0] idx, input logic [7:0] pix, input bit roi,
		input bit mpres, input bit mmov, input bit fend);
		mfha_in_t w;
		w.byte_index   = idx;
		w.pixel_value  = pix;
		w.roi_active   = roi;
		w.mask_present = mpres;
		w.mask_moving  = mmov;
		w.frame_end    = fend;
		// After the first frame a region byte may only hit an index already written.
		if (gen_loaded && w.roi_active && !gen_written.exists(int'(idx)))
			w.roi_active = 1'b0;
		gen_written[int'(idx)] = 1'b1;
		if (fend) gen_loaded = 1'b1;
		pixel_words_pending.push_back(w);
	endtask

	task automatic apb_write(input logic [1:0] reg_idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({reg_idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			REG_HIST_LEN: set_len    = value[HIST_LEN_W-1:0];
			REG_GAIN:     set_gain   = value[GAIN_W-1:0];
			REG_BLACK:    set_black  = value[7:0];
			REG_MARKER:   set_marker = value[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [HIST_LEN_W-1:0] len, input logic [GAIN_W-1:0] gain,
		input logic [7:0] black, input logic [7:0] marker);
		while (pixel_words_pending.size() != 0 || pix_valid || history_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		apb_write(REG_HIST_LEN, PDATA_W'(len));
		apb_write(REG_GAIN, PDATA_W'(gain));
		apb_write(REG_BLACK, PDATA_W'(black));
		apb_write(REG_MARKER, PDATA_W'(marker));
		settings_count++;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [HIST_LEN_W-1:0] len, input logic [GAIN_W-1:0] gain,
		input logic [7:0] black, input logic [7:0] marker, input int unsigned n_items);
		int unsigned queued, n;
		bit          noisy, mask_on, roi;
		logic [17:0] idx, last_idx;
		logic [7:0]  pix;
		apply_settings(len, gain, black, marker);
		queued = 0;
		last_idx = index_pool[0];
		while (queued < n_items) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			// A noisy frame scrambles the flags and may end anywhere or never.
			noisy = ($urandom_range(0, 7) == 0);
			mask_on = 1'($urandom_range(0, 1));
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 15))
					0:          idx = 18'($urandom);
					1, 2, 3, 4: idx = last_idx;
					default:    idx = index_pool[$urandom_range(0, 31)];
				endcase
				last_idx = idx;
				if ($urandom_range(0, 7) == 0)
					pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					pix = 8'($urandom);
				roi = noisy ? 1'($urandom) : ($urandom_range(0, 9) != 0);
				queue_fields(idx, pix, roi, noisy ? 1'($urandom) : mask_on, 1'($urandom),
					noisy ? ($urandom_range(0, 2) == 0) : (i == n - 1));
			end
			queued += n;
		end
	endtask

	// Sender: bursts of words from the pending queue, separated by random gaps.
	always @(posedge clk) begin
		logic     take, next_valid;
		mfha_in_t next_word;
		take = pix_valid && !pix_stall;
		next_valid = pix_valid;
		next_word = pix_data;
		if (take) begin
			history_expected.push_back(predict_history_word(pix_data));
			void'(pixel_words_pending.pop_front());
			words_accepted++;
		end
		if (!pix_valid || take) begin
			if (gap_left > 0) begin
				gap_left--;
				next_valid = 1'b0;
			end else if (pixel_words_pending.size() != 0) begin
				next_valid = 1'b1;
				next_word = pixel_words_pending[0];
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				next_valid = 1'b0;
			end
		end
		pix_valid <= next_valid;
		pix_data  <= next_word;
	end

	// Receiver: checks each word against the oldest prediction and stalls on its own pattern.
	always @(posedge clk) begin
		mfha_out_t want;
		bit        hold_now;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (history_expected.size() == 0) begin
				if (fault_count < 10)
					$display("result %0d arrived with nothing expected: %h %h %h %b",
						results_seen, res_data.history_address, res_data.history_byte,
						res_data.average_value, res_data.frame_done);
				fault_count++;
			end else begin
				want = history_expected.pop_front();
				if (res_data.history_address !== want.history_address ||
					res_data.history_byte !== want.history_byte ||
					res_data.average_value !== want.average_value ||
					res_data.frame_done !== want.frame_done) begin
					if (fault_count < 10) begin
						$display("result %0d: got addr %h byte %h avg %h done %b",
							results_seen, res_data.history_address,
							res_data.history_byte, res_data.average_value,
							res_data.frame_done);
						$display("result %0d: want addr %h byte %h avg %h done %b",
							results_seen, want.history_address, want.history_byte,
							want.average_value, want.frame_done);
					end
					fault_count++;
				end
			end
		end
		if (stall_phase_left == 0) begin
			stall_phase_left = 50;
			case ($urandom_range(0, 4))
				0, 1:    stall_pct = 0;
				2:       stall_pct = 30;
				3:       stall_pct = 60;
				default: stall_pct = 85;
			endcase
		end
		stall_phase_left--;
		// One long hold-off lets the pipeline fill and push back on the sender.
		if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		hold_now = (hold_left > 0);
		if (hold_now) hold_left--;
		res_stall <= hold_now || ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		#(64'd8 * 64'd400000);
		$display("masked_frame_history_and_average_core_tb: errors");
		$finish;
	end

	initial begin
		int unsigned drain_cycles;
		index_pool[0] = '0;
		index_pool[1] = '1;
		for (int i = 2; i < 32; i++) index_pool[i] = 18'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First frame under reset settings: every region average loads straight from the pixel, others from the black level.
		queue_fields(18'd0, 8'd0, 1, 0, 0, 0);
		queue_fields(18'h3FFFF, 8'hFF, 1, 0, 0, 0);
		queue_fields(18'd1, 8'h80, 0, 0, 0, 0);
		queue_fields(18'd2, 8'd77, 1, 1, 1, 0);
		queue_fields(18'd3, 8'd200, 1, 1, 0, 0);
		queue_fields(18'd4, 8'd9, 1, 0, 1, 0);
		queue_fields(18'd5, 8'hFF, 0, 1, 1, 0);
		queue_fields(18'd0, 8'd50, 1, 0, 0, 0);
		queue_fields(18'h3FFFF, 8'd1, 1, 0, 0, 1);
		// Averages are read back now; one index back to back runs into the update stages.
		queue_fields(18'd0, 8'hFF, 1, 0, 0, 0);
		queue_fields(18'd0, 8'h00, 1, 0, 0, 0);
		queue_fields(18'd0, 8'h80, 1, 0, 0, 0);
		queue_fields(18'h3FFFF, 8'h00, 1, 1, 1, 1);
		// A zero length behaves as one and a zero gain holds every region average.
		apply_settings(7'd0, 17'd0, 8'hFF, 8'hFF);
		queue_fields(18'd2, 8'd10, 1, 0, 0, 0);
		queue_fields(18'd3, 8'd10, 1, 1, 1, 0);
		queue_fields(18'd1, 8'd10, 0, 0, 0, 0);
		queue_fields(18'd4, 8'hFF, 1, 0, 0, 1);
		// Length and gain above their limits are clamped.
		apply_settings(7'h7F, 17'h1FFFF, 8'd0, 8'h5A);
		queue_fields(18'd5, 8'd33, 1, 0, 0, 1);
		queue_fields(18'd0, 8'd200, 1, 1, 1, 1);
		queue_fields(18'd3, 8'd0, 1, 0, 0, 1);
		queue_fields(18'h3FFFF, 8'd99, 1, 0, 0, 0);
		// Shrinking the ring leaves the slot past its end, so the block restarts at slot 0.
		apply_settings(7'd2, 17'd1, 8'd16, 8'd0);
		queue_fields(18'd2, 8'd255, 1, 0, 0, 1);
		queue_fields(18'd2, 8'd0, 1, 0, 0, 1);

		run_phase(7'd64, 17'd1024, 8'($urandom), 8'($urandom), 360);
		run_phase(7'd4, 17'd16384, 8'd0, 8'hFF, 300);
		run_phase(7'd1, GAIN_ONE, 8'hFF, 8'd0, 240);
		run_phase(7'd100, 17'd1, 8'($urandom), 8'($urandom), 300);
		run_phase(7'($urandom_range(2, 63)), 17'($urandom_range(1, 65536)),
			8'($urandom), 8'($urandom), 300);
		run_phase(7'd0, 17'd0, BLACK_LEVEL_RST, MARKER_RST, 300);

		drain_cycles = 0;
		while ((pixel_words_pending.size() != 0 || pix_valid || history_expected.size() != 0)
			&& drain_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES + 4) @(negedge clk);
		if (pixel_words_pending.size() != 0 || history_expected.size() != 0) begin
			$display("%0d words never sent, %0d results never arrived",
				pixel_words_pending.size(), history_expected.size());
			fault_count++;
		end
		$display("sent %0d pixel words over %0d closed frames under %0d register settings",
			words_accepted, frames_closed, settings_count + 1);
		$display("checked %0d results, %0d faults", results_seen, fault_count);
		if (fault_count == 0) begin
			$display("masked_frame_history_and_average_core_tb: clean");
		end else begin
			$display("masked_frame_history_and_average_core_tb: errors");
		end
		$finish;
	end

endmodule
